FILE: src/part_pkg.sv
package part_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int ANGLE_WIDTH = 16;

   localparam int CSR_DATA_WIDTH  = (COORD_WIDTH > ANGLE_WIDTH) ? COORD_WIDTH : ANGLE_WIDTH;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OPERATION      = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROTATION_ANGLE = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OFFSET_X       = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OFFSET_Y       = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OFFSET_Z       = 3'd4;

   localparam logic [1:0] OP_ROT_X     = 2'd0;
   localparam logic [1:0] OP_ROT_Y     = 2'd1;
   localparam logic [1:0] OP_ROT_Z     = 2'd2;
   localparam logic [1:0] OP_TRANSLATE = 2'd3;

   // sine and cosine: signed Q2.16
   localparam int TRIG_WIDTH = 18;
   localparam logic signed [TRIG_WIDTH-1:0] TRIG_ONE = 18'sd65536;

   // series evaluation works in unsigned Q62
   localparam int WORK_WIDTH = 64;
   localparam logic [WORK_WIDTH-1:0] HALF_PI_Q62 = 64'h6487ED5110B4611B;
   localparam logic [WORK_WIDTH-1:0] ONE_Q62     = 64'h4000000000000000;
   localparam int TERM_LIMIT = 39;

   typedef struct packed {
      logic                         busy;
      logic signed [TRIG_WIDTH-1:0] sine;
      logic signed [TRIG_WIDTH-1:0] cosine;
   } trig_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic signed [COORD_WIDTH-1:0] z;
      logic                          overflow;
   } result_type;

endpackage

FILE: src/point_axis_rotate_translate.sv
// A beat taken on the request side reaches the rsp_ side through an input register and a result register.
// Throughput: one point per cycle while rsp_stall is low and no angle write or series run holds req_stall.
// A rotation_angle write starts the sine/cosine series unit; req_stall stays high while it runs.
// Reset (synchronous): pipeline empty, configuration registers zero, sine 0 and cosine 1 (angle zero).
module point_axis_rotate_translate (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [part_pkg::COORD_WIDTH-1:0]  req_x_in,
   input  logic signed [part_pkg::COORD_WIDTH-1:0]  req_y_in,
   input  logic signed [part_pkg::COORD_WIDTH-1:0]  req_z_in,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [part_pkg::COORD_WIDTH-1:0]  rsp_x_out,
   output logic signed [part_pkg::COORD_WIDTH-1:0]  rsp_y_out,
   output logic signed [part_pkg::COORD_WIDTH-1:0]  rsp_z_out,
   output logic                                     rsp_overflow,
   input  logic                                     csr_write,
   input  logic [part_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [part_pkg::CSR_DATA_WIDTH-1:0]      csr_data
);

   localparam int CW = part_pkg::COORD_WIDTH;

   logic [1:0]           operation_ff, operation_in;
   logic signed [CW-1:0] offset_x_ff, offset_x_in;
   logic signed [CW-1:0] offset_y_ff, offset_y_in;
   logic signed [CW-1:0] offset_z_ff, offset_z_in;

   logic                 v1_ff, v1_in;
   logic signed [CW-1:0] x1_ff, y1_ff, z1_ff;
   logic                 v2_ff, v2_in;
   part_pkg::result_type res_ff, res_next;

   part_pkg::trig_type   trig;
   logic                 angle_write;
   logic                 adv1, adv2, req_take;

   assign angle_write = csr_write && (csr_index == part_pkg::CSR_ROTATION_ANGLE);

   part_trig u_trig (
      .clock (clock),
      .reset (reset),
      .start (angle_write),
      .angle (csr_data[part_pkg::ANGLE_WIDTH-1:0]),
      .trig  (trig)
   );

   part_xform u_xform (
      .operation (operation_ff),
      .x         (x1_ff),
      .y         (y1_ff),
      .z         (z1_ff),
      .offset_x  (offset_x_ff),
      .offset_y  (offset_y_ff),
      .offset_z  (offset_z_ff),
      .trig      (trig),
      .result    (res_next)
   );

   always_comb begin
      operation_in = operation_ff;
      offset_x_in  = offset_x_ff;
      offset_y_in  = offset_y_ff;
      offset_z_in  = offset_z_ff;
      if (csr_write) begin
         unique case (csr_index)
            part_pkg::CSR_OPERATION: operation_in = csr_data[1:0];
            part_pkg::CSR_OFFSET_X:  offset_x_in  = csr_data[CW-1:0];
            part_pkg::CSR_OFFSET_Y:  offset_y_in  = csr_data[CW-1:0];
            part_pkg::CSR_OFFSET_Z:  offset_z_in  = csr_data[CW-1:0];
            default: ;
         endcase
      end
   end

   assign adv2      = !v2_ff || !rsp_stall;
   assign adv1      = !v1_ff || adv2;
   assign req_stall = !adv1 || trig.busy || angle_write;
   assign req_take  = req_valid && !req_stall;
   assign v1_in     = adv1 ? req_take : v1_ff;
   assign v2_in     = adv2 ? v1_ff : v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         operation_ff <= part_pkg::OP_ROT_X;
         offset_x_ff  <= '0;
         offset_y_ff  <= '0;
         offset_z_ff  <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
      end else begin
         operation_ff <= operation_in;
         offset_x_ff  <= offset_x_in;
         offset_y_ff  <= offset_y_in;
         offset_z_ff  <= offset_z_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         x1_ff <= req_x_in;
         y1_ff <= req_y_in;
         z1_ff <= req_z_in;
      end
      if (adv2 && v1_ff) begin
         res_ff <= res_next;
      end
   end

   assign rsp_valid    = v2_ff;
   assign rsp_x_out    = res_ff.x;
   assign rsp_y_out    = res_ff.y;
   assign rsp_z_out    = res_ff.z;
   assign rsp_overflow = res_ff.overflow;

endmodule

FILE: src/part_trig.sv
module part_trig (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [part_pkg::ANGLE_WIDTH-1:0]  angle,
   output part_pkg::trig_type                trig
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_UPD  = 2'd3;

   localparam logic [1:0] STEP_THETA = 2'd0;
   localparam logic [1:0] STEP_X2    = 2'd1;
   localparam logic [1:0] STEP_SIN   = 2'd2;
   localparam logic [1:0] STEP_COS   = 2'd3;

   localparam int WW = part_pkg::WORK_WIDTH;
   localparam int HW = WW / 2;
   localparam int AW = part_pkg::ANGLE_WIDTH;
   localparam int TW = part_pkg::TRIG_WIDTH;

   logic [1:0]      state_ff, state_in;
   logic [1:0]      step_ff, step_in;
   logic [6:0]      cnt_ff, cnt_in;
   logic [5:0]      k_ff, k_in;
   logic [WW-1:0]   ma_ff, ma_in, mb_ff, mb_in;
   logic [WW-1:0]   pp_ff, pp_in;
   logic [2*WW-1:0] acc_ff, acc_in;
   logic [WW-1:0]   x2_ff, x2_in;
   logic [WW-1:0]   term_ff, term_in;
   logic [WW-1:0]   sum_ff, sum_in;
   logic [WW-1:0]   quot_ff, quot_in;
   logic [12:0]     rem_ff, rem_in;
   logic [12:0]     div_ff, div_in;
   logic [1:0]      quad_ff, quad_in;
   logic [TW-2:0]   sr_ff, sr_in;
   logic signed [TW-1:0] sine_ff, sine_in, cosine_ff, cosine_in;

   logic [HW-1:0]   a_part, b_part;
   logic [1:0]      prev_idx;
   logic [6:0]      acc_shift;
   logic [2*WW-1:0] acc_sum;
   logic [6:0]      k2;
   logic [12:0]     div_sel;
   logic [13:0]     rem_sh;
   logic            rem_ge;
   logic [WW-1:0]   upd_sum, new_sum, round_sum;
   logic            series_end;
   logic [TW-2:0]   rounded;

   always_comb begin
      a_part    = cnt_ff[0] ? ma_ff[WW-1:HW] : ma_ff[HW-1:0];
      b_part    = cnt_ff[1] ? mb_ff[WW-1:HW] : mb_ff[HW-1:0];
      prev_idx  = cnt_ff[1:0] - 2'd1;
      acc_shift = 7'(({1'b0, prev_idx[0]} + {1'b0, prev_idx[1]}) * HW);
      acc_sum   = acc_ff + ({{WW{1'b0}}, pp_ff} << acc_shift);

      k2 = {k_ff, 1'b0};
      if (step_ff == STEP_SIN) begin
         div_sel = 13'(14'(k2) * 14'(k2 + 7'd1));
      end else begin
         div_sel = 13'(14'(k2 - 7'd1) * 14'(k2));
      end

      rem_sh = {rem_ff, quot_ff[WW-1]};
      rem_ge = rem_sh >= {1'b0, div_ff};

      upd_sum    = k_ff[0] ? (sum_ff - quot_ff) : (sum_ff + quot_ff);
      new_sum    = (quot_ff == '0) ? sum_ff : upd_sum;
      series_end = (quot_ff == '0) || (k_ff == 6'(part_pkg::TERM_LIMIT));
      round_sum  = new_sum + (WW'(1) << 45);
      rounded    = round_sum[62:46];
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cnt_in    = cnt_ff;
      k_in      = k_ff;
      ma_in     = ma_ff;
      mb_in     = mb_ff;
      pp_in     = pp_ff;
      acc_in    = acc_ff;
      x2_in     = x2_ff;
      term_in   = term_ff;
      sum_in    = sum_ff;
      quot_in   = quot_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      quad_in   = quad_ff;
      sr_in     = sr_ff;
      sine_in   = sine_ff;
      cosine_in = cosine_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               quad_in  = angle[AW-1 -: 2];
               ma_in    = {angle[AW-3:0], {(66-AW){1'b0}}};
               mb_in    = part_pkg::HALF_PI_Q62;
               step_in  = STEP_THETA;
               cnt_in   = '0;
               acc_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (cnt_ff != 7'd4) begin
               pp_in = WW'(a_part) * WW'(b_part);
            end
            if (cnt_ff != 7'd0) begin
               acc_in = acc_sum;
            end
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd4) begin
               cnt_in = '0;
               acc_in = '0;
               unique case (step_ff)
                  STEP_THETA: begin
                     term_in = acc_sum[2*WW-1:WW];
                     ma_in   = acc_sum[2*WW-1:WW];
                     mb_in   = acc_sum[2*WW-1:WW];
                     step_in = STEP_X2;
                  end
                  STEP_X2: begin
                     x2_in   = acc_sum[125:62];
                     sum_in  = term_ff;
                     ma_in   = term_ff;
                     mb_in   = acc_sum[125:62];
                     k_in    = 6'd1;
                     step_in = STEP_SIN;
                  end
                  default: begin
                     quot_in  = acc_sum[125:62];
                     rem_in   = '0;
                     div_in   = div_sel;
                     state_in = ST_DIV;
                  end
               endcase
            end
         end
         ST_DIV: begin
            rem_in  = rem_ge ? 13'(rem_sh - {1'b0, div_ff}) : rem_sh[12:0];
            quot_in = {quot_ff[WW-2:0], rem_ge};
            cnt_in  = cnt_ff + 7'd1;
            if (cnt_ff == 7'(WW - 1)) begin
               cnt_in   = '0;
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            acc_in = '0;
            cnt_in = '0;
            if (!series_end) begin
               sum_in   = upd_sum;
               k_in     = k_ff + 6'd1;
               ma_in    = quot_ff;
               mb_in    = x2_ff;
               state_in = ST_MUL;
            end else if (step_ff == STEP_SIN) begin
               sr_in    = rounded;
               sum_in   = part_pkg::ONE_Q62;
               ma_in    = part_pkg::ONE_Q62;
               mb_in    = x2_ff;
               k_in     = 6'd1;
               step_in  = STEP_COS;
               state_in = ST_MUL;
            end else begin
               // fold the first-quadrant pair out to the full turn
               case (quad_ff)
                  2'd0: begin
                     sine_in   = {1'b0, sr_ff};
                     cosine_in = {1'b0, rounded};
                  end
                  2'd1: begin
                     sine_in   = {1'b0, rounded};
                     cosine_in = TW'(0) - {1'b0, sr_ff};
                  end
                  2'd2: begin
                     sine_in   = TW'(0) - {1'b0, sr_ff};
                     cosine_in = TW'(0) - {1'b0, rounded};
                  end
                  default: begin
                     sine_in   = TW'(0) - {1'b0, rounded};
                     cosine_in = {1'b0, sr_ff};
                  end
               endcase
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         step_ff   <= STEP_THETA;
         cnt_ff    <= '0;
         k_ff      <= '0;
         sine_ff   <= '0;
         cosine_ff <= part_pkg::TRIG_ONE;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         cnt_ff    <= cnt_in;
         k_ff      <= k_in;
         sine_ff   <= sine_in;
         cosine_ff <= cosine_in;
      end
   end

   always_ff @(posedge clock) begin
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      pp_ff   <= pp_in;
      acc_ff  <= acc_in;
      x2_ff   <= x2_in;
      term_ff <= term_in;
      sum_ff  <= sum_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      quad_ff <= quad_in;
      sr_ff   <= sr_in;
   end

   assign trig.busy   = (state_ff != ST_IDLE);
   assign trig.sine   = sine_ff;
   assign trig.cosine = cosine_ff;

endmodule

FILE: src/part_xform.sv
module part_xform (
   input  logic [1:0]                               operation,
   input  logic signed [part_pkg::COORD_WIDTH-1:0]  x,
   input  logic signed [part_pkg::COORD_WIDTH-1:0]  y,
   input  logic signed [part_pkg::COORD_WIDTH-1:0]  z,
   input  logic signed [part_pkg::COORD_WIDTH-1:0]  offset_x,
   input  logic signed [part_pkg::COORD_WIDTH-1:0]  offset_y,
   input  logic signed [part_pkg::COORD_WIDTH-1:0]  offset_z,
   input  part_pkg::trig_type                       trig,
   output part_pkg::result_type                     result
);

   localparam int CW = part_pkg::COORD_WIDTH;
   localparam int TW = part_pkg::TRIG_WIDTH;
   localparam int PW = CW + TW;
   localparam int SW = CW + 3;

   // coordinate times Q2.16, rounded to nearest, ties upward
   function automatic logic signed [CW+1:0] scaled(input logic signed [CW-1:0] c,
                                                   input logic signed [TW-1:0] t);
      logic signed [PW-1:0] p;
      p = PW'(c) * PW'(t);
      p = p + PW'(32768);
      return p[PW-1:16];
   endfunction

   // {overflow, clamped value}
   function automatic logic [CW:0] saturate(input logic signed [SW-1:0] v);
      logic ov;
      ov = (v[SW-1:CW-1] != {(SW-CW+1){1'b0}}) && (v[SW-1:CW-1] != {(SW-CW+1){1'b1}});
      if (!ov) begin
         return {1'b0, v[CW-1:0]};
      end else if (v[SW-1]) begin
         return {1'b1, 1'b1, {(CW-1){1'b0}}};
      end else begin
         return {1'b1, 1'b0, {(CW-1){1'b1}}};
      end
   endfunction

   logic signed [CW-1:0] first, second;
   logic signed [SW-1:0] turn_a, turn_b;
   logic [CW:0]          sat_a, sat_b, sat_x, sat_y, sat_z;

   always_comb begin
      unique case (operation)
         part_pkg::OP_ROT_X: begin
            first  = z;
            second = y;
         end
         part_pkg::OP_ROT_Y: begin
            first  = x;
            second = z;
         end
         default: begin
            first  = x;
            second = y;
         end
      endcase

      turn_a = SW'(scaled(first, trig.cosine)) - SW'(scaled(second, trig.sine));
      turn_b = SW'(scaled(first, trig.sine)) + SW'(scaled(second, trig.cosine));
      sat_a  = saturate(turn_a);
      sat_b  = saturate(turn_b);
      sat_x  = saturate(SW'(x) + SW'(offset_x));
      sat_y  = saturate(SW'(y) + SW'(offset_y));
      sat_z  = saturate(SW'(z) + SW'(offset_z));

      result.x        = x;
      result.y        = y;
      result.z        = z;
      result.overflow = 1'b0;
      unique case (operation)
         part_pkg::OP_ROT_X: begin
            result.z        = sat_a[CW-1:0];
            result.y        = sat_b[CW-1:0];
            result.overflow = sat_a[CW] | sat_b[CW];
         end
         part_pkg::OP_ROT_Y: begin
            result.x        = sat_a[CW-1:0];
            result.z        = sat_b[CW-1:0];
            result.overflow = sat_a[CW] | sat_b[CW];
         end
         part_pkg::OP_ROT_Z: begin
            result.x        = sat_a[CW-1:0];
            result.y        = sat_b[CW-1:0];
            result.overflow = sat_a[CW] | sat_b[CW];
         end
         default: begin
            result.x        = sat_x[CW-1:0];
            result.y        = sat_y[CW-1:0];
            result.z        = sat_z[CW-1:0];
            result.overflow = sat_x[CW] | sat_y[CW] | sat_z[CW];
         end
      endcase
   end

endmodule
